FILE: hdl/descriptor_access_checker_unit_defines.svh
// Assertion macros shared by the checker RTL.
`ifndef DESCRIPTOR_ACCESS_CHECKER_UNIT_DEFINES_SVH
`define DESCRIPTOR_ACCESS_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define DAC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define DAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/dac_pkg.sv
package dac_pkg;

  localparam int HEAP_DEPTH = 4096;
  localparam int LIVE_WORDS = 1024;
  localparam int HEAP_AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int LIVE_AW = (LIVE_WORDS > 1) ? $clog2(LIVE_WORDS) : 1;

  localparam int SLOT_W     = 12;
  localparam int COUNT_W    = 13;
  localparam int COOKIE_W   = 15;
  localparam int LIVE_IDX_W = 10;
  localparam int WORD_W     = 32;
  localparam int FAULT_W    = 4;
  localparam int CFG_W      = 64;
  localparam int REG_IDX_W  = 2;

  localparam int COOKIE_WORD_SHIFT = 5;
  localparam int COOKIE_BIT_MASK   = 31;

  // Transaction modes as they arrive on the request channel.
  localparam logic [1:0] MODE_CHECK      = 2'd0;
  localparam logic [1:0] MODE_WRITE_ENT  = 2'd1;
  localparam logic [1:0] MODE_WRITE_LIVE = 2'd2;
  localparam logic [1:0] MODE_READ_CAP   = 2'd3;

  // Operation kinds handed from the front end to the back end.
  localparam logic [1:0] OP_CHECK = 2'd0;
  localparam logic [1:0] OP_ENTRY = 2'd1;
  localparam logic [1:0] OP_LIVE  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_DESC_TOTAL    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEAP_ID       = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAP_TIMESTAMP = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SHADER_HASH   = 2'd3;

  // Fault bit positions.
  localparam int FAULT_RANGE     = 0;
  localparam int FAULT_MASK_MISS = 1;
  localparam int FAULT_DEAD      = 2;
  localparam int FAULT_TIME      = 3;

  typedef struct packed {
    logic [1:0]            mode;
    logic [SLOT_W-1:0]     slot;
    logic [WORD_W-1:0]     required_type;
    logic [WORD_W-1:0]     instruction_tag;
    logic [COOKIE_W-1:0]   entry_cookie;
    logic [WORD_W-1:0]     entry_time;
    logic [WORD_W-1:0]     entry_type;
    logic [LIVE_IDX_W-1:0] live_index;
    logic [WORD_W-1:0]     live_bits;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  returned_slot;
    logic [FAULT_W-1:0]  fault_bits;
    logic                first_fault;
    logic [WORD_W-1:0]   fault_total;
    logic [FAULT_W-1:0]  captured_bits;
    logic [SLOT_W-1:0]   captured_slot;
    logic [COOKIE_W-1:0] captured_cookie;
    logic [WORD_W-1:0]   captured_heap;
    logic [WORD_W-1:0]   captured_required;
    logic [WORD_W-1:0]   captured_actual;
    logic [WORD_W-1:0]   captured_instruction;
  } rsp_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [SLOT_W-1:0]     slot;
    logic                  slot_ok;
    logic [WORD_W-1:0]     required;
    logic [WORD_W-1:0]     tag;
    logic [COOKIE_W-1:0]   cookie;
    logic [WORD_W-1:0]     stamp;
    logic [WORD_W-1:0]     etype;
    logic [LIVE_IDX_W-1:0] live_index;
    logic [WORD_W-1:0]     live_bits;
    logic                  live_ok;
  } op_t;

  typedef struct packed {
    logic [COUNT_W-1:0] desc_total;
    logic [WORD_W-1:0]  heap_id;
    logic [WORD_W-1:0]  map_timestamp;
  } cfg_t;

  typedef struct packed {
    logic [COOKIE_W-1:0] cookie;
    logic [WORD_W-1:0]   stamp;
    logic [WORD_W-1:0]   etype;
  } entry_t;

endpackage

FILE: hdl/dac_front.sv
module dac_front
  import dac_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic q_valid,
  output op_t  q_item,
  input  logic q_pop
);

  op_t        op_in;
  op_t        q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  // Classify the transaction and range-check its table indexes.
  always_comb begin
    op_in            = '0;
    op_in.slot       = req_data.slot;
    op_in.slot_ok    = 32'(req_data.slot) < HEAP_DEPTH;
    op_in.required   = req_data.required_type;
    op_in.tag        = req_data.instruction_tag;
    op_in.cookie     = req_data.entry_cookie;
    op_in.stamp      = req_data.entry_time;
    op_in.etype      = req_data.entry_type;
    op_in.live_index = req_data.live_index;
    op_in.live_bits  = req_data.live_bits;
    op_in.live_ok    = 32'(req_data.live_index) < LIVE_WORDS;
    case (req_data.mode)
      MODE_CHECK:      op_in.kind = OP_CHECK;
      MODE_WRITE_ENT:  op_in.kind = OP_ENTRY;
      MODE_WRITE_LIVE: op_in.kind = OP_LIVE;
      MODE_READ_CAP:   op_in.kind = OP_READ;
      default:         op_in.kind = OP_READ;
    endcase
  end

  assign req_stall = (count == 2'd2);
  assign push      = req_valid && !req_stall;
  assign q_valid   = (count != 2'd0);
  assign q_item    = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/dac_back.sv
module dac_back
  import dac_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_valid,
  input  op_t  q_item,
  output logic q_pop,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ENTRY = 2'd1;
  localparam logic [1:0] ST_LIVE  = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  op_t                 op;
  entry_t              ent_mem [HEAP_DEPTH];
  entry_t              ent_rd;
  logic                ent_ok;
  logic [WORD_W-1:0]   live_mem [LIVE_WORDS];
  logic [WORD_W-1:0]   live_rd;
  logic                live_ok;
  logic [WORD_W-1:0]   fault_counter;
  logic [WORD_W-1:0]   fault_counter_next;
  rsp_t                capture;
  rsp_t                capture_next;
  rsp_t                rsp_next;
  logic                rsp_load;
  logic                out_free;
  logic                ent_we;
  logic                live_we;
  logic                live_re;
  entry_t              ent_eff;
  logic [WORD_W-1:0]   word_eff;
  logic [COOKIE_W-COOKIE_WORD_SHIFT-1:0] cookie_word;
  logic [COOKIE_WORD_SHIFT-1:0]          cookie_bit;
  logic [FAULT_W-1:0]  fbits;
  logic                first;

  assign out_free = !rsp_valid || !rsp_stall;
  assign q_pop    = (state == ST_IDLE) && q_valid && out_free;
  assign ent_we   = q_pop && (q_item.kind == OP_ENTRY) && q_item.slot_ok;
  assign live_we  = q_pop && (q_item.kind == OP_LIVE) && q_item.live_ok;
  assign live_re  = (state == ST_ENTRY);

  // Out-of-range slots read as an all-zero entry.
  assign ent_eff     = ent_ok ? ent_rd : '0;
  assign cookie_word = ent_eff.cookie[COOKIE_W-1:COOKIE_WORD_SHIFT];
  assign cookie_bit  = COOKIE_WORD_SHIFT'(ent_eff.cookie & COOKIE_W'(COOKIE_BIT_MASK));
  assign word_eff    = live_ok ? live_rd : '0;

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[HEAP_AW'(q_item.slot)] <= '{cookie: q_item.cookie, stamp: q_item.stamp,
                                          etype: q_item.etype};
    end
    if (q_pop) begin
      ent_rd <= ent_mem[HEAP_AW'(q_item.slot)];
      ent_ok <= q_item.slot_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (live_we) begin
      live_mem[LIVE_AW'(q_item.live_index)] <= q_item.live_bits;
    end
    if (live_re) begin
      live_rd <= live_mem[LIVE_AW'(cookie_word)];
      live_ok <= 32'(cookie_word) < LIVE_WORDS;
    end
  end

  always_comb begin
    fbits = '0;
    fbits[FAULT_RANGE]     = {1'b0, op.slot} >= cfg.desc_total;
    fbits[FAULT_MASK_MISS] = (ent_eff.etype & op.required) != op.required;
    fbits[FAULT_DEAD]      = !word_eff[cookie_bit];
    fbits[FAULT_TIME]      = ent_eff.stamp > cfg.map_timestamp;
    first = (fbits != '0) && (fault_counter == '0);
  end

  always_comb begin
    state_next         = state;
    fault_counter_next = fault_counter;
    capture_next       = capture;
    rsp_load           = 1'b0;
    rsp_next           = capture;
    rsp_next.returned_slot = '0;
    rsp_next.fault_bits    = '0;
    rsp_next.first_fault   = 1'b0;
    rsp_next.fault_total   = fault_counter;
    case (state)
      ST_IDLE: begin
        if (q_pop) begin
          if (q_item.kind == OP_CHECK) begin
            state_next = ST_ENTRY;
          end else begin
            rsp_load = 1'b1;
          end
        end
      end
      ST_ENTRY: begin
        state_next = ST_LIVE;
      end
      ST_LIVE: begin
        state_next = ST_IDLE;
        rsp_load   = 1'b1;
        if (fbits != '0) begin
          fault_counter_next = fault_counter + 32'd1;
          if (first) begin
            capture_next.captured_bits        = fbits;
            capture_next.captured_slot        = op.slot;
            capture_next.captured_cookie      = ent_eff.cookie;
            capture_next.captured_heap        = cfg.heap_id;
            capture_next.captured_required    = op.required;
            capture_next.captured_actual      = ent_eff.etype;
            capture_next.captured_instruction = op.tag;
          end
        end
        rsp_next               = capture_next;
        rsp_next.returned_slot = (fbits != '0) ? cfg.desc_total : {1'b0, op.slot};
        rsp_next.fault_bits    = fbits;
        rsp_next.first_fault   = first;
        rsp_next.fault_total   = fault_counter_next;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op <= q_item;
    end
    if (rsp_load) begin
      rsp_data <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fault_counter <= '0;
      capture       <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      fault_counter <= fault_counter_next;
      capture       <= capture_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/descriptor_access_checker_unit.sv
// Channel    Direction  Signals                       Transaction
// ---------  ---------  ----------------------------  -------------------------------------
// request    in         req_valid/req_stall/req_data  one check, write or capture read
// response   out        rsp_valid/rsp_stall/rsp_data  one result per request
// config     in         cfg_we/cfg_index/cfg_data     one register write, no read-back
//
// A check passes the back end in order (entry table read, then live-bitmap read
// addressed by the entry's cookie, then fault evaluation); writes and capture
// reads are answered from the idle state. The two table reads of a check are dependent.
// A 2-entry queue keeps taking requests while the back end works or the response waits.
// Reset (rst, synchronous) clears control state, fault counter and capture record;
// the tables have no clearing pass and must be written before they are read.
// rsp_stall holds the response register; req_stall rises only when the queue is full.
`include "descriptor_access_checker_unit_defines.svh"

module descriptor_access_checker_unit
  import dac_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req_data,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp_data,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg;
  logic q_valid;
  op_t  q_item;
  logic q_pop;

  // Configuration registers. The shader hash has no register in this block,
  // so its write is accepted and dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DESC_TOTAL:    cfg.desc_total    <= cfg_data[COUNT_W-1:0];
        REG_HEAP_ID:       cfg.heap_id       <= cfg_data[WORD_W-1:0];
        REG_MAP_TIMESTAMP: cfg.map_timestamp <= cfg_data[WORD_W-1:0];
        REG_SHADER_HASH:   cfg <= cfg;
        default:           cfg <= cfg;
      endcase
    end
  end

  // Front end: classify each transaction and hold it in the queue.
  dac_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // Back end: table reads and writes, fault evaluation, counter, capture,
  // and the response register.
  dac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  // A first fault always brings the counter to one.
  `DAC_ASSERT_SAME(a_first_counts_one, rsp_valid && rsp_data.first_fault,
                   rsp_data.fault_total == 32'd1, "first fault with counter not one")

  // A first fault carries its own bits into the capture record.
  `DAC_ASSERT_SAME(a_first_captures, rsp_valid && rsp_data.first_fault,
                   (rsp_data.fault_bits != '0) && (rsp_data.captured_bits == rsp_data.fault_bits),
                   "capture record does not match first fault")

  // A faulting check returns the descriptor count as its slot.
  `DAC_ASSERT_SAME(a_fault_fallback, rsp_valid && (rsp_data.fault_bits != '0),
                   rsp_data.returned_slot == cfg.desc_total,
                   "faulting check did not return descriptor count")

  // The request side stalls only when the queue holds work for the back end.
  `DAC_ASSERT_SAME(a_stall_means_queued, req_stall, q_valid,
                   "request stalled with an empty queue")

endmodule
